### design/wlfu_pkg.sv
// Shared types and constants of the weighted line fit update block.
// Holds the multiply-accumulate program, sequencer state codes and fixed-point constants.
// No dependencies.
`default_nettype none

package wlfu_pkg;

   localparam int CNT_W = 6;
   localparam int SUM_W = 64;
   localparam int ACC_W = 128;
   localparam int REM_W = 160;
   localparam int Q_W   = 33;

   localparam logic [CNT_W-1:0] MAX_POINTS = 6'd32;
   localparam logic [31:0] FIX_999       = 32'd65470464;
   localparam logic [31:0] DET_FLOOR_RST = 32'd1;
   localparam logic [3:0]  LAST_UPDATE_OP = 4'd6;
   localparam logic [3:0]  LAST_OP        = 4'd12;

   // request opcodes
   localparam logic OP_ADD    = 1'b0;
   localparam logic OP_REMOVE = 1'b1;

   typedef enum logic [3:0] {
      SRC_W, SRC_R, SRC_Z, SRC_ONE, SRC_T1, SRC_T2,
      SRC_SW, SRC_SWR, SRC_SWZ, SRC_SWRZ, SRC_SWZZ
   } src_type;

   typedef enum logic [1:0] {INIT_ZERO, INIT_SUM, INIT_KEEP} init_type;

   typedef enum logic [1:0] {SGN_PLUS, SGN_MINUS, SGN_OP} sgn_type;

   typedef enum logic [3:0] {
      DST_T1, DST_T2, DST_SW, DST_SWR, DST_SWZ, DST_SWRZ, DST_SWZZ,
      DST_DET, DST_NUMS, DST_NUMI
   } dst_type;

   typedef enum logic [1:0] {
      DIV_SLOPE, DIV_INTERCEPT, DIV_SLOPE_ERR, DIV_INTERCEPT_ERR
   } div_type;

   typedef enum logic [6:0] {
      ST_IDLE  = 7'b0000001,
      ST_MAC   = 7'b0000010,
      ST_DPREP = 7'b0000100,
      ST_DFIX  = 7'b0001000,
      ST_DSET  = 7'b0010000,
      ST_DSTEP = 7'b0100000,
      ST_DONE  = 7'b1000000
   } state_type;

   typedef struct packed {
      src_type  a;
      src_type  b;
      init_type init;
      sgn_type  sgn;
      dst_type  dst;
   } mac_op_type;

   // Ops 0..6 fold the point into the sums, ops 7..12 form determinant and numerators.
   function automatic mac_op_type mac_program(input logic [3:0] idx);
      mac_op_type op;
      begin
         unique case (idx)
            4'd0:    op = '{SRC_R,    SRC_Z,    INIT_ZERO, SGN_PLUS,  DST_T1};
            4'd1:    op = '{SRC_Z,    SRC_Z,    INIT_ZERO, SGN_PLUS,  DST_T2};
            4'd2:    op = '{SRC_W,    SRC_ONE,  INIT_SUM,  SGN_OP,    DST_SW};
            4'd3:    op = '{SRC_W,    SRC_R,    INIT_SUM,  SGN_OP,    DST_SWR};
            4'd4:    op = '{SRC_W,    SRC_Z,    INIT_SUM,  SGN_OP,    DST_SWZ};
            4'd5:    op = '{SRC_W,    SRC_T1,   INIT_SUM,  SGN_OP,    DST_SWRZ};
            4'd6:    op = '{SRC_W,    SRC_T2,   INIT_SUM,  SGN_OP,    DST_SWZZ};
            4'd7:    op = '{SRC_SWZZ, SRC_SW,   INIT_ZERO, SGN_PLUS,  DST_DET};
            4'd8:    op = '{SRC_SWZ,  SRC_SWZ,  INIT_KEEP, SGN_MINUS, DST_DET};
            4'd9:    op = '{SRC_SWRZ, SRC_SW,   INIT_ZERO, SGN_PLUS,  DST_NUMS};
            4'd10:   op = '{SRC_SWR,  SRC_SWZ,  INIT_KEEP, SGN_MINUS, DST_NUMS};
            4'd11:   op = '{SRC_SWR,  SRC_SWZZ, INIT_ZERO, SGN_PLUS,  DST_NUMI};
            4'd12:   op = '{SRC_SWRZ, SRC_SWZ,  INIT_KEEP, SGN_MINUS, DST_NUMI};
            default: op = '{SRC_R,    SRC_Z,    INIT_ZERO, SGN_PLUS,  DST_T1};
         endcase
         return op;
      end
   endfunction

endpackage

`default_nettype wire

### design/weighted_line_fit_update.sv
// Weighted straight-line fit, updated one point per request.
// Depends on wlfu_pkg (program table, state codes, constants).
`default_nettype none

// Each request adds or removes one weighted point (z, r) and returns one response with
// the current fit r = intercept + slope * z, the two variance terms, the point and used
// counts and a rejected flag (add when 32 points are held, remove when none are held).
// All arithmetic runs on one 32x32 multiplier and one 160-bit compare/subtract unit
// under a small sequencer, and req_ready is high only while the block is idle.
// A rejected request goes straight to the response. When at most two points remain, the
// 7 multiply-accumulate ops that update the sums run on the shared multiplier and the
// last fit is held; a full solve runs 13 multiply-accumulate ops, a determinant check
// (ST_DPREP, ST_DFIX), then four quotients from the one-bit-per-cycle divider, for
// slope, intercept and the two variance terms. A waiting response holds the next result
// until rsp_ready takes it. det_floor is written through csr_ and resets to 1;
// determinants of magnitude below it, or zero, are taken as 1.0.
module weighted_line_fit_update (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic               req_opcode,
   input  wire logic signed [23:0] req_hit_z,
   input  wire logic        [19:0] req_hit_r,
   input  wire logic        [15:0] req_hit_weight,
   input  wire logic               req_hit_used,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic signed [31:0]      rsp_slope,
   output logic signed [31:0]      rsp_intercept,
   output logic        [31:0]      rsp_slope_err2,
   output logic        [31:0]      rsp_intercept_err2,
   output logic                    rsp_fit_ready,
   output logic [wlfu_pkg::CNT_W-1:0] rsp_point_count,
   output logic [wlfu_pkg::CNT_W-1:0] rsp_used_count,
   output logic                    rsp_rejected,
   input  wire logic               csr_write_en,
   input  wire logic        [31:0] csr_write_data
);
   import wlfu_pkg::*;

   // sequencer
   state_type         state_ff, state_in;
   logic [3:0]        op_ff, op_in;
   logic [2:0]        pc_ff, pc_in;
   div_type           div_ff, div_in;
   logic [5:0]        step_ff, step_in;

   // request payload
   logic [23:0]       z_ff, z_in;
   logic [19:0]       r_ff, r_in;
   logic [15:0]       w_ff, w_in;
   logic              remove_ff, remove_in;
   logic              rej_ff, rej_in;

   // fit state
   logic [CNT_W-1:0]  points_ff, points_in;
   logic [CNT_W-1:0]  used_ff, used_in;
   logic [SUM_W-1:0]  sum_w_ff, sum_w_in;
   logic [SUM_W-1:0]  sum_wr_ff, sum_wr_in;
   logic [SUM_W-1:0]  sum_wz_ff, sum_wz_in;
   logic [SUM_W-1:0]  sum_wrz_ff, sum_wrz_in;
   logic [SUM_W-1:0]  sum_wzz_ff, sum_wzz_in;
   logic [31:0]       slope_ff, slope_in;
   logic [31:0]       icpt_ff, icpt_in;
   logic [31:0]       slope_err_ff, slope_err_in;
   logic [31:0]       icpt_err_ff, icpt_err_in;
   logic [31:0]       floor_ff, floor_in;

   // multiply-accumulate datapath
   logic [SUM_W-1:0]  t1_ff, t1_in;
   logic [SUM_W-1:0]  t2_ff, t2_in;
   logic [ACC_W-1:0]  det_ff, det_in;
   logic [ACC_W-1:0]  nums_ff, nums_in;
   logic [ACC_W-1:0]  numi_ff, numi_in;
   logic [ACC_W-1:0]  acc_ff, acc_in;
   logic [SUM_W-1:0]  mag_a_ff, mag_a_in;
   logic [SUM_W-1:0]  mag_b_ff, mag_b_in;
   logic              psign_ff, psign_in;
   logic [SUM_W-1:0]  prod_ff, prod_in;
   logic [1:0]        prod_sh_ff, prod_sh_in;

   // divider datapath
   logic [ACC_W-1:0]  dmag_ff, dmag_in;
   logic              dneg_ff, dneg_in;
   logic [REM_W-1:0]  rem_ff, rem_in;
   logic [REM_W-1:0]  dsh_ff, dsh_in;
   logic [Q_W-1:0]    q_ff, q_in;
   logic              qneg_ff, qneg_in;

   // response register
   logic              rsp_valid_ff, rsp_valid_in;
   logic [31:0]       rsp_slope_ff, rsp_slope_in;
   logic [31:0]       rsp_icpt_ff, rsp_icpt_in;
   logic [31:0]       rsp_serr_ff, rsp_serr_in;
   logic [31:0]       rsp_ierr_ff, rsp_ierr_in;
   logic              rsp_fit_ff, rsp_fit_in;
   logic [CNT_W-1:0]  rsp_points_ff, rsp_points_in;
   logic [CNT_W-1:0]  rsp_used_ff, rsp_used_in;
   logic              rsp_rej_ff, rsp_rej_in;

   mac_op_type        cur_op;
   logic [SUM_W-1:0]  src_val [16];
   logic [SUM_W-1:0]  opa, opb, dst_sum;
   logic [1:0]        part;
   logic [31:0]       half_a, half_b;
   logic [ACC_W-1:0]  addend;
   logic              req_take, rsp_load;
   logic              reject_now;
   logic              div_signed;
   logic [5:0]        last_step;
   logic [ACC_W-1:0]  div_num, div_nmag;
   logic              step_ge, sat;
   logic [31:0]       mag32, quot;

   assign cur_op = mac_program(op_ff);

   // operand sources, indexed by the program's source codes
   always_comb begin
      for (int i = 0; i < 16; i++) begin
         src_val[i] = '0;
      end
      src_val[SRC_W]    = {48'b0, w_ff};
      src_val[SRC_R]    = {44'b0, r_ff};
      src_val[SRC_Z]    = {{40{z_ff[23]}}, z_ff};
      src_val[SRC_ONE]  = 64'd1;
      src_val[SRC_T1]   = t1_ff;
      src_val[SRC_T2]   = t2_ff;
      src_val[SRC_SW]   = sum_w_ff;
      src_val[SRC_SWR]  = sum_wr_ff;
      src_val[SRC_SWZ]  = sum_wz_ff;
      src_val[SRC_SWRZ] = sum_wrz_ff;
      src_val[SRC_SWZZ] = sum_wzz_ff;
   end

   assign opa = src_val[cur_op.a];
   assign opb = src_val[cur_op.b];

   always_comb begin
      case (cur_op.dst)
         DST_SW:   dst_sum = sum_w_ff;
         DST_SWR:  dst_sum = sum_wr_ff;
         DST_SWZ:  dst_sum = sum_wz_ff;
         DST_SWRZ: dst_sum = sum_wrz_ff;
         DST_SWZZ: dst_sum = sum_wzz_ff;
         default:  dst_sum = '0;
      endcase
   end

   // partial product pc-1: a_lo*b_lo, a_lo*b_hi, a_hi*b_lo, a_hi*b_hi
   assign part   = 2'(pc_ff - 3'd1);
   assign half_a = part[1] ? mag_a_ff[63:32] : mag_a_ff[31:0];
   assign half_b = part[0] ? mag_b_ff[63:32] : mag_b_ff[31:0];

   always_comb begin
      case (prod_sh_ff)
         2'd1:    addend = {32'b0, prod_ff, 32'b0};
         2'd2:    addend = {prod_ff, 64'b0};
         default: addend = {64'b0, prod_ff};
      endcase
   end

   // divider selection
   assign div_signed = (div_ff == DIV_SLOPE) || (div_ff == DIV_INTERCEPT);
   assign last_step  = div_signed ? 6'd31 : 6'd32;

   always_comb begin
      unique case (div_ff)
         DIV_SLOPE:     div_num = nums_ff;
         DIV_INTERCEPT: div_num = numi_ff;
         DIV_SLOPE_ERR: div_num = {{64{sum_w_ff[63]}}, sum_w_ff};
         default:       div_num = {{64{sum_wzz_ff[63]}}, sum_wzz_ff};
      endcase
   end

   assign div_nmag = div_num[ACC_W-1] ? ACC_W'(0) - div_num : div_num;
   assign step_ge  = (rem_ff >= dsh_ff);

   assign req_take   = req_valid && req_ready;
   assign reject_now = req_opcode ? (points_ff == '0) : (points_ff >= MAX_POINTS);
   assign rsp_load   = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      pc_in         = pc_ff;
      div_in        = div_ff;
      step_in       = step_ff;
      z_in          = z_ff;
      r_in          = r_ff;
      w_in          = w_ff;
      remove_in     = remove_ff;
      rej_in        = rej_ff;
      points_in     = points_ff;
      used_in       = used_ff;
      sum_w_in      = sum_w_ff;
      sum_wr_in     = sum_wr_ff;
      sum_wz_in     = sum_wz_ff;
      sum_wrz_in    = sum_wrz_ff;
      sum_wzz_in    = sum_wzz_ff;
      slope_in      = slope_ff;
      icpt_in       = icpt_ff;
      slope_err_in  = slope_err_ff;
      icpt_err_in   = icpt_err_ff;
      floor_in      = csr_write_en ? csr_write_data : floor_ff;
      t1_in         = t1_ff;
      t2_in         = t2_ff;
      det_in        = det_ff;
      nums_in       = nums_ff;
      numi_in       = numi_ff;
      acc_in        = acc_ff;
      mag_a_in      = mag_a_ff;
      mag_b_in      = mag_b_ff;
      psign_in      = psign_ff;
      prod_in       = prod_ff;
      prod_sh_in    = prod_sh_ff;
      dmag_in       = dmag_ff;
      dneg_in       = dneg_ff;
      rem_in        = rem_ff;
      dsh_in        = dsh_ff;
      q_in          = q_ff;
      qneg_in       = qneg_ff;
      sat           = 1'b0;
      mag32         = '0;
      quot          = '0;

      unique case (state_ff)
         ST_IDLE: begin
            // latch the request, settle counts and go straight to the response on reject
            if (req_take) begin
               z_in      = req_hit_z;
               r_in      = req_hit_r;
               w_in      = req_hit_weight;
               remove_in = req_opcode;
               rej_in    = reject_now;
               op_in     = '0;
               pc_in     = '0;
               if (reject_now) begin
                  state_in = ST_DONE;
               end else begin
                  state_in = ST_MAC;
                  if (req_opcode) begin
                     points_in = points_ff - 6'd1;
                     if (req_hit_used && (used_ff != '0)) begin
                        used_in = used_ff - 6'd1;
                     end
                  end else begin
                     points_in = points_ff + 6'd1;
                     used_in   = used_ff + {5'b0, req_hit_used};
                  end
               end
            end
         end

         ST_MAC: begin
            // pc 0: take magnitudes and init; pc 1-4: multiply; pc 2-5: accumulate
            if (pc_ff == 3'd0) begin
               mag_a_in = opa[63] ? 64'd0 - opa : opa;
               mag_b_in = opb[63] ? 64'd0 - opb : opb;
               case (cur_op.sgn)
                  SGN_MINUS: psign_in = ~(opa[63] ^ opb[63]);
                  SGN_OP:    psign_in = opa[63] ^ opb[63] ^ remove_ff;
                  default:   psign_in = opa[63] ^ opb[63];
               endcase
               case (cur_op.init)
                  INIT_ZERO: acc_in = '0;
                  INIT_SUM:  acc_in = {64'b0, dst_sum};
                  default:   acc_in = acc_ff;
               endcase
            end
            if ((pc_ff >= 3'd1) && (pc_ff <= 3'd4)) begin
               prod_in    = {32'b0, half_a} * {32'b0, half_b};
               prod_sh_in = 2'({1'b0, part[1]} + {1'b0, part[0]});
            end
            if (pc_ff >= 3'd2) begin
               acc_in = psign_ff ? acc_ff - addend : acc_ff + addend;
            end
            if (pc_ff == 3'd5) begin
               pc_in = '0;
               case (cur_op.dst)
                  DST_T1:   t1_in      = acc_in[63:0];
                  DST_T2:   t2_in      = acc_in[63:0];
                  DST_SW:   sum_w_in   = acc_in[63:0];
                  DST_SWR:  sum_wr_in  = acc_in[63:0];
                  DST_SWZ:  sum_wz_in  = acc_in[63:0];
                  DST_SWRZ: sum_wrz_in = acc_in[63:0];
                  DST_SWZZ: sum_wzz_in = acc_in[63:0];
                  DST_DET:  det_in     = acc_in;
                  DST_NUMS: nums_in    = acc_in;
                  default:  numi_in    = acc_in;
               endcase
               // hold the last fit when two points or fewer remain
               if ((op_ff == LAST_UPDATE_OP) && (points_ff <= 6'd2)) begin
                  state_in = ST_DONE;
               end else if (op_ff == LAST_OP) begin
                  state_in = ST_DPREP;
               end else begin
                  op_in = op_ff + 4'd1;
               end
            end else begin
               pc_in = pc_ff + 3'd1;
            end
         end

         ST_DPREP: begin
            dmag_in  = det_ff[ACC_W-1] ? ACC_W'(0) - det_ff : det_ff;
            dneg_in  = det_ff[ACC_W-1];
            state_in = ST_DFIX;
         end

         ST_DFIX: begin
            // replace a zero or tiny determinant by 1.0 in Q.24
            if ((dmag_ff == '0) ||
                ((dmag_ff[127:64] == '0) && (dmag_ff[63:0] < {32'b0, floor_ff}))) begin
               dmag_in = ACC_W'(1) << 24;
               dneg_in = 1'b0;
            end
            div_in   = DIV_SLOPE;
            state_in = ST_DSET;
         end

         ST_DSET: begin
            qneg_in = div_num[ACC_W-1] ^ dneg_ff;
            q_in    = '0;
            step_in = '0;
            unique case (div_ff)
               DIV_SLOPE:     rem_in = {32'b0, div_nmag} << 16;
               DIV_INTERCEPT: rem_in = {32'b0, div_nmag} << 12;
               DIV_SLOPE_ERR: rem_in = {32'b0, div_nmag} << 32;
               default:       rem_in = {32'b0, div_nmag} << 24;
            endcase
            dsh_in   = div_signed ? ({32'b0, dmag_ff} << 31) : ({32'b0, dmag_ff} << 32);
            state_in = ST_DSTEP;
         end

         ST_DSTEP: begin
            // first step is the saturation test, the rest give one quotient bit each
            rem_in  = step_ge ? rem_ff - dsh_ff : rem_ff;
            dsh_in  = dsh_ff >> 1;
            q_in    = {q_ff[31:0], step_ge};
            step_in = step_ff + 6'd1;
            if (step_ff == last_step) begin
               if (div_signed) begin
                  sat   = q_in[31];
                  mag32 = sat ? (qneg_ff ? 32'h8000_0000 : 32'h7FFF_FFFF) : q_in[31:0];
                  quot  = qneg_ff ? 32'd0 - mag32 : mag32;
               end else begin
                  sat  = q_in[32];
                  quot = qneg_ff ? 32'd0 : (sat ? 32'hFFFF_FFFF : q_in[31:0]);
               end
               unique case (div_ff)
                  DIV_SLOPE:     slope_in     = quot;
                  DIV_INTERCEPT: icpt_in      = quot;
                  DIV_SLOPE_ERR: slope_err_in = quot;
                  default:       icpt_err_in  = quot;
               endcase
               if (div_ff == DIV_INTERCEPT_ERR) begin
                  state_in = ST_DONE;
               end else begin
                  div_in   = div_type'(div_ff + 2'd1);
                  state_in = ST_DSET;
               end
            end
         end

         ST_DONE: begin
            // wait for the response register to free up
            if (rsp_load) begin
               state_in = ST_IDLE;
            end
         end

         default: state_in = ST_IDLE;
      endcase
   end

   // response register: drop when taken, load when the result is final
   always_comb begin
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_slope_in  = rsp_slope_ff;
      rsp_icpt_in   = rsp_icpt_ff;
      rsp_serr_in   = rsp_serr_ff;
      rsp_ierr_in   = rsp_ierr_ff;
      rsp_fit_in    = rsp_fit_ff;
      rsp_points_in = rsp_points_ff;
      rsp_used_in   = rsp_used_ff;
      rsp_rej_in    = rsp_rej_ff;
      if (rsp_load) begin
         rsp_valid_in  = 1'b1;
         rsp_slope_in  = slope_ff;
         rsp_icpt_in   = icpt_ff;
         rsp_serr_in   = slope_err_ff;
         rsp_ierr_in   = icpt_err_ff;
         rsp_fit_in    = (points_ff > 6'd2);
         rsp_points_in = points_ff;
         rsp_used_in   = used_ff;
         rsp_rej_in    = rej_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         op_ff        <= '0;
         pc_ff        <= '0;
         div_ff       <= DIV_SLOPE;
         step_ff      <= '0;
         points_ff    <= '0;
         used_ff      <= '0;
         sum_w_ff     <= '0;
         sum_wr_ff    <= '0;
         sum_wz_ff    <= '0;
         sum_wrz_ff   <= '0;
         sum_wzz_ff   <= '0;
         slope_ff     <= 32'd0 - FIX_999;
         icpt_ff      <= 32'd0 - FIX_999;
         slope_err_ff <= FIX_999;
         icpt_err_ff  <= FIX_999;
         floor_ff     <= DET_FLOOR_RST;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         op_ff        <= op_in;
         pc_ff        <= pc_in;
         div_ff       <= div_in;
         step_ff      <= step_in;
         points_ff    <= points_in;
         used_ff      <= used_in;
         sum_w_ff     <= sum_w_in;
         sum_wr_ff    <= sum_wr_in;
         sum_wz_ff    <= sum_wz_in;
         sum_wrz_ff   <= sum_wrz_in;
         sum_wzz_ff   <= sum_wzz_in;
         slope_ff     <= slope_in;
         icpt_ff      <= icpt_in;
         slope_err_ff <= slope_err_in;
         icpt_err_ff  <= icpt_err_in;
         floor_ff     <= floor_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      z_ff          <= z_in;
      r_ff          <= r_in;
      w_ff          <= w_in;
      remove_ff     <= remove_in;
      rej_ff        <= rej_in;
      t1_ff         <= t1_in;
      t2_ff         <= t2_in;
      det_ff        <= det_in;
      nums_ff       <= nums_in;
      numi_ff       <= numi_in;
      acc_ff        <= acc_in;
      mag_a_ff      <= mag_a_in;
      mag_b_ff      <= mag_b_in;
      psign_ff      <= psign_in;
      prod_ff       <= prod_in;
      prod_sh_ff    <= prod_sh_in;
      dmag_ff       <= dmag_in;
      dneg_ff       <= dneg_in;
      rem_ff        <= rem_in;
      dsh_ff        <= dsh_in;
      q_ff          <= q_in;
      qneg_ff       <= qneg_in;
      rsp_slope_ff  <= rsp_slope_in;
      rsp_icpt_ff   <= rsp_icpt_in;
      rsp_serr_ff   <= rsp_serr_in;
      rsp_ierr_ff   <= rsp_ierr_in;
      rsp_fit_ff    <= rsp_fit_in;
      rsp_points_ff <= rsp_points_in;
      rsp_used_ff   <= rsp_used_in;
      rsp_rej_ff    <= rsp_rej_in;
   end

   assign req_ready          = (state_ff == ST_IDLE);
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_slope          = rsp_slope_ff;
   assign rsp_intercept      = rsp_icpt_ff;
   assign rsp_slope_err2     = rsp_serr_ff;
   assign rsp_intercept_err2 = rsp_ierr_ff;
   assign rsp_fit_ready      = rsp_fit_ff;
   assign rsp_point_count    = rsp_points_ff;
   assign rsp_used_count     = rsp_used_ff;
   assign rsp_rejected       = rsp_rej_ff;

endmodule

`default_nettype wire

### tb/wlfu_checker.sv
// Scoreboard for weighted_line_fit_update: watches requests, responses and det_floor writes.
// Predicts each response in 128-bit exact arithmetic and compares it field by field.
// Depends on wlfu_pkg (widths, opcodes, MAX_POINTS, FIX_999, DET_FLOOR_RST).
`default_nettype none

module wlfu_checker (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   input  wire logic               req_ready,
   input  wire logic               req_opcode,
   input  wire logic signed [23:0] req_hit_z,
   input  wire logic        [19:0] req_hit_r,
   input  wire logic        [15:0] req_hit_weight,
   input  wire logic               req_hit_used,
   input  wire logic               rsp_valid,
   input  wire logic               rsp_ready,
   input  wire logic signed [31:0] rsp_slope,
   input  wire logic signed [31:0] rsp_intercept,
   input  wire logic        [31:0] rsp_slope_err2,
   input  wire logic        [31:0] rsp_intercept_err2,
   input  wire logic               rsp_fit_ready,
   input  wire logic [wlfu_pkg::CNT_W-1:0] rsp_point_count,
   input  wire logic [wlfu_pkg::CNT_W-1:0] rsp_used_count,
   input  wire logic               rsp_rejected,
   input  wire logic               csr_write_en,
   input  wire logic        [31:0] csr_write_data,
   output int                      fail_count,
   output int                      fits_pending
);
   timeunit 1ns;
   timeprecision 1ps;

   import wlfu_pkg::*;

   typedef struct {
      logic [31:0] slope;
      logic [31:0] intercept;
      logic [31:0] slope_err2;
      logic [31:0] intercept_err2;
      logic        fit_ready;
      logic [5:0]  point_count;
      logic [5:0]  used_count;
      logic        rejected;
   } fit_result_type;

   fit_result_type expected_fits[$];

   logic [63:0] acc_w, acc_wr, acc_wz, acc_wrz, acc_wzz;
   logic [5:0]  n_points, n_used;
   logic [31:0] cur_slope, cur_intercept, cur_slope_err, cur_intercept_err;
   logic [31:0] floor_reg;

   function automatic logic signed [127:0] smul(input logic [63:0] a, input logic [63:0] b);
      logic signed [127:0] pa;
      logic signed [127:0] pb;
      pa = $signed(a);
      pb = $signed(b);
      return pa * pb;
   endfunction

   // floor(|n| * 2^s / |d|), clipped at lim
   function automatic logic [63:0] scaled_quot(input logic signed [127:0] n,
         input logic signed [127:0] d, input int s, input logic [63:0] lim);
      logic [127:0] an;
      logic [127:0] ad;
      logic [160:0] q;
      an = n[127] ? -n : n;
      ad = d[127] ? -d : d;
      q = ({33'b0, an} << s) / {33'b0, ad};
      return (q > {97'b0, lim}) ? lim : q[63:0];
   endfunction

   function automatic logic [31:0] quot_s(input logic signed [127:0] n,
         input logic signed [127:0] d, input int s);
      logic        neg;
      logic [63:0] m;
      neg = n[127] ^ d[127];
      m = scaled_quot(n, d, s, neg ? 64'h8000_0000 : 64'h7FFF_FFFF);
      return neg ? -m[31:0] : m[31:0];
   endfunction

   function automatic logic [31:0] quot_u(input logic signed [127:0] n,
         input logic signed [127:0] d, input int s);
      if (n[127] != d[127]) return 32'd0;
      return 32'(scaled_quot(n, d, s, 64'hFFFF_FFFF));
   endfunction

   task automatic solve_normal_eq();
      logic signed [127:0] det;
      logic [127:0]        mag;
      logic signed [127:0] num;
      det = smul(acc_wzz, acc_w) - smul(acc_wz, acc_wz);
      mag = det[127] ? -det : det;
      // tiny or zero determinant is taken as 1.0 in Q.24
      if (mag == 0 || mag < {96'b0, floor_reg}) det = 128'sd1 << 24;
      num = smul(acc_wrz, acc_w) - smul(acc_wr, acc_wz);
      cur_slope = quot_s(num, det, 16);
      num = smul(acc_wr, acc_wzz) - smul(acc_wrz, acc_wz);
      cur_intercept = quot_s(num, det, 12);
      cur_slope_err = quot_u($signed(acc_w), det, 32);
      cur_intercept_err = quot_u($signed(acc_wzz), det, 24);
   endtask

   task automatic predict_fit_update(input logic op, input logic signed [23:0] z,
         input logic [19:0] r, input logic [15:0] w, input logic used,
         output fit_result_type res);
      logic [63:0] zx, wr, wz, wrz, wzz;
      logic        rej;
      zx  = {{40{z[23]}}, z};
      wr  = 64'(w) * 64'(r);
      wz  = 64'(w) * zx;
      wrz = wr * zx;
      wzz = wz * zx;
      rej = (op == OP_ADD) ? (n_points >= MAX_POINTS) : (n_points == 0);
      if (!rej) begin
         if (op == OP_ADD) begin
            n_points = n_points + 6'd1;
            if (used) n_used = n_used + 6'd1;
            acc_w += 64'(w); acc_wr += wr; acc_wz += wz; acc_wrz += wrz; acc_wzz += wzz;
         end else begin
            n_points = n_points - 6'd1;
            if (used && n_used > 0) n_used = n_used - 6'd1;
            acc_w -= 64'(w); acc_wr -= wr; acc_wz -= wz; acc_wrz -= wrz; acc_wzz -= wzz;
         end
         if (n_points > 2) solve_normal_eq();
      end
      res.slope          = cur_slope;
      res.intercept      = cur_intercept;
      res.slope_err2     = cur_slope_err;
      res.intercept_err2 = cur_intercept_err;
      res.fit_ready      = n_points > 2;
      res.point_count    = n_points;
      res.used_count     = n_used;
      res.rejected       = rej;
   endtask

   task automatic check_field(input string name, input logic [31:0] exp_v,
         input logic [31:0] act_v);
      if (exp_v !== act_v) begin
         $display("%0t: %s mismatch: expected %h, got %h", $time, name, exp_v, act_v);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      fit_result_type exp_r;
      fit_result_type new_r;
      if (reset) begin
         acc_w = 0; acc_wr = 0; acc_wz = 0; acc_wrz = 0; acc_wzz = 0;
         n_points = 0;
         n_used = 0;
         cur_slope = -FIX_999;
         cur_intercept = -FIX_999;
         cur_slope_err = FIX_999;
         cur_intercept_err = FIX_999;
         floor_reg = DET_FLOOR_RST;
         expected_fits.delete();
         fits_pending = 0;
         fail_count = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_fits.size() == 0) begin
               $display("%0t: response with none expected", $time);
               fail_count++;
            end else begin
               exp_r = expected_fits.pop_front();
               check_field("slope", exp_r.slope, rsp_slope);
               check_field("intercept", exp_r.intercept, rsp_intercept);
               check_field("slope_err2", exp_r.slope_err2, rsp_slope_err2);
               check_field("intercept_err2", exp_r.intercept_err2, rsp_intercept_err2);
               check_field("fit_ready", 32'(exp_r.fit_ready), 32'(rsp_fit_ready));
               check_field("point_count", 32'(exp_r.point_count), 32'(rsp_point_count));
               check_field("used_count", 32'(exp_r.used_count), 32'(rsp_used_count));
               check_field("rejected", 32'(exp_r.rejected), 32'(rsp_rejected));
            end
         end
         if (req_valid && req_ready) begin
            predict_fit_update(req_opcode, req_hit_z, req_hit_r, req_hit_weight,
                               req_hit_used, new_r);
            expected_fits.insert(expected_fits.size(), new_r);
         end
         if (csr_write_en) floor_reg = csr_write_data;
         fits_pending = expected_fits.size();
      end
   end

endmodule

`default_nettype wire

### tb/tb.sv
// Top of the weighted_line_fit_update testbench: clock, reset, stimulus and verdict.
// Depends on wlfu_pkg, weighted_line_fit_update and wlfu_checker.
`default_nettype none

module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import wlfu_pkg::*;

   localparam int   CYCLE_LIMIT = 3_000_000;
   localparam int   HOLD_CYCLES = 600;

   typedef struct {
      logic signed [23:0] z;
      logic        [19:0] r;
      logic        [15:0] w;
      logic               used;
   } point_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic               req_valid = 1'b0;
   logic               req_ready;
   logic               req_opcode = OP_ADD;
   logic signed [23:0] req_hit_z = '0;
   logic        [19:0] req_hit_r = '0;
   logic        [15:0] req_hit_weight = '0;
   logic               req_hit_used = 1'b0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic signed [31:0] rsp_slope;
   logic signed [31:0] rsp_intercept;
   logic        [31:0] rsp_slope_err2;
   logic        [31:0] rsp_intercept_err2;
   logic               rsp_fit_ready;
   logic [CNT_W-1:0]   rsp_point_count;
   logic [CNT_W-1:0]   rsp_used_count;
   logic               rsp_rejected;
   logic               csr_write_en = 1'b0;
   logic        [31:0] csr_write_data = '0;

   int fail_count;
   int fits_pending;

   // points the block currently holds, as far as the stimulus knows
   point_type held_pts[$];

   // long receiver hold: top bumps hold_asked, receiver serves it once
   int hold_asked = 0;
   int hold_served = 0;
   int hold_left = 0;
   int cycle_count = 0;

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   weighted_line_fit_update uut (
      .clock, .reset,
      .req_valid, .req_ready, .req_opcode, .req_hit_z, .req_hit_r, .req_hit_weight,
      .req_hit_used,
      .rsp_valid, .rsp_ready, .rsp_slope, .rsp_intercept, .rsp_slope_err2,
      .rsp_intercept_err2, .rsp_fit_ready, .rsp_point_count, .rsp_used_count,
      .rsp_rejected,
      .csr_write_en, .csr_write_data
   );

   wlfu_checker checker_i (
      .clock, .reset,
      .req_valid, .req_ready, .req_opcode, .req_hit_z, .req_hit_r, .req_hit_weight,
      .req_hit_used,
      .rsp_valid, .rsp_ready, .rsp_slope, .rsp_intercept, .rsp_slope_err2,
      .rsp_intercept_err2, .rsp_fit_ready, .rsp_point_count, .rsp_used_count,
      .rsp_rejected,
      .csr_write_en, .csr_write_data,
      .fail_count, .fits_pending
   );

   // Mostly short gaps, now and then a long one, often none at all.
   function automatic int gap_len();
      int p;
      p = $urandom_range(99);
      if (p < 45) return 0;
      if (p < 92) return $urandom_range(1, 4);
      return $urandom_range(20, 120);
   endfunction

   // Receiver: random stalls, plus one long hold on request from the stimulus.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_ready <= 1'b0;
         hold_left <= hold_left - 1;
      end else if (hold_asked != hold_served) begin
         hold_served <= hold_asked;
         hold_left <= HOLD_CYCLES;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= (gap_len() == 0) || ($urandom_range(3) != 0);
      end
   end

   // Timeout guard.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // Offer one request and hold it until accepted; leaves valid high on return.
   task automatic send_request(input logic op, input point_type p);
      req_valid      <= 1'b1;
      req_opcode     <= op;
      req_hit_z      <= p.z;
      req_hit_r      <= p.r;
      req_hit_weight <= p.w;
      req_hit_used   <= p.used;
      forever begin
         @(negedge clock);
         if (req_ready) break;
      end
      @(posedge clock);
   endtask

   // Drop valid for a random gap, or keep it high for a back-to-back request.
   task automatic sender_gap();
      int n;
      n = gap_len();
      if (n > 0) begin
         req_valid <= 1'b0;
         repeat (n) @(posedge clock);
      end
   endtask

   // Add a point and track it, or remove a tracked point.
   task automatic add_point(input point_type p);
      send_request(OP_ADD, p);
      if (held_pts.size() < MAX_POINTS) held_pts.insert(held_pts.size(), p);
      sender_gap();
   endtask

   task automatic remove_held(input int idx);
      point_type p;
      p = held_pts[idx];
      held_pts.delete(idx);
      send_request(OP_REMOVE, p);
      sender_gap();
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      forever begin
         @(negedge clock);
         if (fits_pending == 0) break;
      end
      @(posedge clock);
   endtask

   // Program det_floor only while idle.
   task automatic write_floor(input logic [31:0] v);
      wait_drained();
      repeat (4) @(posedge clock);
      csr_write_en   <= 1'b1;
      csr_write_data <= v;
      @(posedge clock);
      csr_write_en   <= 1'b0;
      @(posedge clock);
   endtask

   function automatic point_type rand_point();
      point_type p;
      int        k;
      k = $urandom_range(9);
      if (k < 6) begin
         // modest values give well-conditioned fits
         p.z = 24'($signed($urandom_range(0, 8000)) - 4000);
         p.r = 20'($urandom_range(0, 4000));
         p.w = 16'($urandom_range(1, 1024));
      end else begin
         p.z = 24'($urandom);
         p.r = 20'($urandom);
         p.w = 16'($urandom);
      end
      p.used = 1'($urandom_range(1));
      return p;
   endfunction

   function automatic point_type mk_point(input logic signed [23:0] z, input logic [19:0] r,
         input logic [15:0] w, input logic used);
      point_type p;
      p.z = z; p.r = r; p.w = w; p.used = used;
      return p;
   endfunction

   // One random phase: mostly proper add/remove of held points, some noise.
   task automatic run_phase(input int n_items, input bit with_hold);
      int        i;
      int        k;
      point_type p;
      for (i = 0; i < n_items; i++) begin
         if (with_hold && i == n_items / 2) hold_asked <= hold_asked + 1;
         if (i == n_items / 3) wait_drained();
         k = $urandom_range(99);
         if (held_pts.size() == 0) begin
            if (k < 8) begin
               send_request(OP_REMOVE, rand_point());   // rejected: nothing held
               sender_gap();
            end else begin
               add_point(rand_point());
            end
         end else if (held_pts.size() >= MAX_POINTS) begin
            if (k < 15) begin
               send_request(OP_ADD, rand_point());      // rejected: store full
               sender_gap();
            end else begin
               remove_held($urandom_range(held_pts.size() - 1));
            end
         end else if (k < 4) begin
            // remove a point never added: counts drop, sums go astray
            p = rand_point();
            void'(held_pts.pop_front());
            send_request(OP_REMOVE, p);
            sender_gap();
         end else if (k < 62) begin
            add_point(rand_point());
         end else begin
            remove_held($urandom_range(held_pts.size() - 1));
         end
      end
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: remove when empty, field extremes, tiny fits, full store.
      send_request(OP_REMOVE, mk_point(24'sd0, 20'd0, 16'd0, 1'b1));
      sender_gap();
      add_point(mk_point(-24'sd8388608, 20'hFFFFF, 16'hFFFF, 1'b1));
      add_point(mk_point(24'sd8388607, 20'd0, 16'hFFFF, 1'b0));
      add_point(mk_point(24'sd0, 20'h80000, 16'd0, 1'b1));
      add_point(mk_point(24'sd16, 20'd32, 16'd256, 1'b0));
      remove_held(0);
      remove_held(0);
      remove_held(0);
      remove_held(0);
      // identical z everywhere: zero determinant
      add_point(mk_point(24'sd80, 20'd100, 16'd256, 1'b1));
      add_point(mk_point(24'sd80, 20'd200, 16'd256, 1'b1));
      add_point(mk_point(24'sd80, 20'd300, 16'd256, 1'b0));
      // remove the last point with its used flag set although it was added unused
      send_request(OP_REMOVE, mk_point(24'sd80, 20'd300, 16'd256, 1'b1));
      void'(held_pts.pop_back());
      sender_gap();
      while (held_pts.size() < MAX_POINTS) add_point(rand_point());
      send_request(OP_ADD, mk_point(24'sd5, 20'd5, 16'd5, 1'b1));
      sender_gap();

      write_floor(32'd0);
      run_phase(200, 1'b0);
      write_floor(32'hFFFF_FFFF);
      run_phase(200, 1'b1);
      write_floor($urandom);
      run_phase(180, 1'b0);
      write_floor(32'd1);
      run_phase(200, 1'b0);

      wait_drained();
      repeat (20) @(posedge clock);
      if (fail_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

`default_nettype wire

### filelist.f
design/wlfu_pkg.sv
design/weighted_line_fit_update.sv
tb/wlfu_checker.sv
tb/tb.sv
